@@ sv/modular_division_prime_unit_assert.svh @@
// Assertion macros for the modular division unit.
// Included by the top level; no other dependencies.
`ifndef MODULAR_DIVISION_PRIME_UNIT_ASSERT_SVH
`define MODULAR_DIVISION_PRIME_UNIT_ASSERT_SVH

// Checked every cycle outside reset.
`define MDP_CHECK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checked every cycle, reset included.
`define MDP_NEXT(lbl, clk, pre, post, msg) \
    lbl: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

@@ sv/mdp_pkg.sv @@
// Shared widths, types and constant helpers for the modular division unit.
// No dependencies.
`default_nettype none

package mdp_pkg;

    localparam int DIVIDEND_W = 63;
    localparam int DIVISOR_W  = 30;
    localparam int QUOTIENT_W = 30;
    localparam int RES_W      = 31;
    localparam int WORD_W     = 32;
    localparam int MONT_STAGES = 4;

    typedef logic [RES_W-1:0]  res_t;
    typedef logic [WORD_W-1:0] word_t;

    // Returns -m^-1 mod 2^32 for odd m, by Newton iteration.
    function automatic word_t neg_inv(input word_t m);
        word_t inv;
        inv = m;
        for (int i = 0; i < 5; i++) begin
            inv = inv * (word_t'(2) - m * inv);
        end
        return word_t'(0) - inv;
    endfunction

endpackage

`default_nettype wire

@@ sv/modular_division_prime_unit.sv @@
// Square-and-multiply over B = bit length of MODULUS - 2 (B is 30 at the default
// modulus); each Montgomery multiplier is four stages.
// Throughput: one request per cycle; a stalled output stalls the whole pipe.
// Reset (synchronous, active low) clears only the valid bits.
// Depends on mdp_pkg, mdp_mont, mdp_step and the assertion header.
`default_nettype none

`include "modular_division_prime_unit_assert.svh"

module modular_division_prime_unit #(
    parameter int unsigned MODULUS = 998244353
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [mdp_pkg::DIVIDEND_W-1:0] s_dividend,
    input  wire logic [mdp_pkg::DIVISOR_W-1:0]  s_divisor,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [mdp_pkg::QUOTIENT_W-1:0]    m_quotient
);
    import mdp_pkg::*;

    localparam logic [31:0] MOD_C  = 32'(MODULUS);
    localparam logic [31:0] EXP    = MOD_C - 32'd2;
    localparam int          NB     = $clog2(64'(EXP) + 64'd1);
    localparam longint unsigned R_MOD_L = (64'd1 << 32) % MODULUS;
    localparam longint unsigned R2_L    = (R_MOD_L * R_MOD_L) % MODULUS;
    localparam logic [31:0] R_MOD  = 32'(R_MOD_L);
    localparam logic [31:0] R2     = 32'(R2_L);
    localparam logic [31:0] MP     = neg_inv(MOD_C);
    localparam int          NUM_D  = NB * MONT_STAGES;
    localparam int          LAT    = (NB + 2) * MONT_STAGES;

    logic           en;
    logic [LAT-1:0] vld_reg, vld_next;
    res_t           acc_w  [NB+1];
    res_t           base_w [NB+1];
    res_t           hi_part, lo_part;
    word_t          num_sum;
    res_t           num_next;
    res_t           num_reg [NUM_D];
    res_t           q_res;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    always_comb begin
        vld_next = {vld_reg[LAT-2:0], s_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // Front end: divisor into Montgomery form, dividend reduced as hi * R + lo.
    mdp_mont #(.MOD(MOD_C), .MP(MP)) u_base (
        .aclk(aclk), .en(en), .a(RES_W'(R2)), .b(word_t'(s_divisor)), .r(base_w[0])
    );

    mdp_mont #(.MOD(MOD_C), .MP(MP)) u_hi (
        .aclk(aclk), .en(en), .a(RES_W'(R2)),
        .b(word_t'(s_dividend[DIVIDEND_W-1:WORD_W])), .r(hi_part)
    );

    mdp_mont #(.MOD(MOD_C), .MP(MP)) u_lo (
        .aclk(aclk), .en(en), .a(RES_W'(R_MOD)),
        .b(s_dividend[WORD_W-1:0]), .r(lo_part)
    );

    always_comb begin
        num_sum  = word_t'(hi_part) + word_t'(lo_part);
        num_next = (num_sum >= MOD_C) ? RES_W'(num_sum - MOD_C) : num_sum[RES_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg[0] <= num_next;
            for (int i = 1; i < NUM_D; i++) begin
                num_reg[i] <= num_reg[i-1];
            end
        end
    end

    // The accumulator starts at one in Montgomery form.
    assign acc_w[0] = RES_W'(R_MOD);

    for (genvar g = 0; g < NB; g++) begin : g_step
        mdp_step #(.MOD(MOD_C), .MP(MP), .RMOD(R_MOD), .EBIT(EXP[g])) u_step (
            .aclk(aclk), .en(en),
            .acc_in(acc_w[g]), .base_in(base_w[g]),
            .acc_out(acc_w[g+1]), .base_out(base_w[g+1])
        );
    end

    // Montgomery product of inverse * R with the plain numerator gives a plain result.
    mdp_mont #(.MOD(MOD_C), .MP(MP)) u_final (
        .aclk(aclk), .en(en), .a(acc_w[NB]), .b(word_t'(num_reg[NUM_D-1])), .r(q_res)
    );

    assign m_quotient = q_res[QUOTIENT_W-1:0];

    `MDP_CHECK(a_ready_rule, aclk, aresetn, s_ready == (!m_valid || m_ready), "ready mismatch")
    `MDP_NEXT(a_reset_clear, aclk, !aresetn, !m_valid, "valid after reset")
    `MDP_CHECK(a_range, aclk, aresetn, !m_valid || (32'(m_quotient) < MOD_C), "result range")

endmodule

`default_nettype wire

@@ sv/mdp_mont.sv @@
// Four-stage pipelined Montgomery multiplier with R = 2^32.
// Depends on mdp_pkg.
`default_nettype none

module mdp_mont #(
    parameter logic [31:0] MOD = 32'd998244353,
    parameter logic [31:0] MP  = 32'd998244351
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire mdp_pkg::res_t  a,
    input  wire mdp_pkg::word_t b,
    output mdp_pkg::res_t       r
);
    import mdp_pkg::*;

    logic [62:0] t1_reg, t1_next;
    logic [62:0] t2_reg;
    logic [62:0] t3_reg;
    word_t       m_reg, m_next;
    logic [63:0] p_reg, p_next;
    res_t        r_reg, r_next;
    logic [63:0] sum;
    word_t       u;

    always_comb begin
        t1_next = 63'(a) * 63'(b);
        m_next  = word_t'(t1_reg[31:0] * MP);
        p_next  = 64'(m_reg) * 64'(MOD);
        // The low half of the sum is zero by construction of m.
        sum     = 64'(t3_reg) + p_reg;
        u       = sum[63:32];
        r_next  = (u >= MOD) ? RES_W'(u - MOD) : u[RES_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg <= t1_next;
            t2_reg <= t1_reg;
            m_reg  <= m_next;
            t3_reg <= t2_reg;
            p_reg  <= p_next;
            r_reg  <= r_next;
        end
    end

    assign r = r_reg;

endmodule

`default_nettype wire

@@ sv/mdp_step.sv @@
// One square-and-multiply step: squares the base and, if the exponent bit
// is set, multiplies it into the accumulator. Depends on mdp_pkg, mdp_mont.
`default_nettype none

module mdp_step #(
    parameter logic [31:0] MOD  = 32'd998244353,
    parameter logic [31:0] MP   = 32'd998244351,
    parameter logic [31:0] RMOD = 32'd1,
    parameter bit          EBIT = 1'b1
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire mdp_pkg::res_t  acc_in,
    input  wire mdp_pkg::res_t  base_in,
    output mdp_pkg::res_t       acc_out,
    output mdp_pkg::res_t       base_out
);
    import mdp_pkg::*;

    word_t mul_op;

    // Multiplying by R mod M in Montgomery form leaves the accumulator unchanged.
    assign mul_op = EBIT ? word_t'(base_in) : RMOD;

    mdp_mont #(.MOD(MOD), .MP(MP)) u_sq (
        .aclk(aclk), .en(en), .a(base_in), .b(word_t'(base_in)), .r(base_out)
    );

    mdp_mont #(.MOD(MOD), .MP(MP)) u_mul (
        .aclk(aclk), .en(en), .a(acc_in), .b(mul_op), .r(acc_out)
    );

endmodule

`default_nettype wire
